// ===== src/tfc_pkg.sv =====
// ----------------------------------------------------------------------------
// tfc_pkg: shared types and constants of the TCP flow classifier
// Holds the field widths, the header constants and the flow entry record.
// ----------------------------------------------------------------------------
`default_nettype none

package tfc_pkg;

	localparam int unsigned MAX_FLOWS_DEFAULT = 64;

	localparam int unsigned IN_W  = 120;	// packed input fields, 15 bytes
	localparam int unsigned OUT_W = 64;	// 58 result bits padded to 8 bytes
	localparam int unsigned IDX_OUT_W = 6;

	localparam logic [7:0]  ETH_HDR_BYTES   = 8'd14;
	localparam logic [3:0]  MIN_HDR_WORDS   = 4'd5;	// 20 bytes
	localparam logic [15:0] RTMP_PORT_RESET = 16'd1935;

	typedef struct packed {
		logic [31:0] first_addr;
		logic [31:0] second_addr;
		logic [31:0] byte_total;
		logic        rtmp_mark;
	} flow_entry_t;

	// unordered address pair compare
	function automatic logic pair_match(input flow_entry_t e, input logic [31:0] src,
			input logic [31:0] dst);
		pair_match = ((e.first_addr == src) && (e.second_addr == dst)) ||
			((e.first_addr == dst) && (e.second_addr == src));
	endfunction

endpackage

`default_nettype wire

// ===== src/tcp_flow_classifier.sv =====
// ----------------------------------------------------------------------------
// tcp_flow_classifier
// Per-frame payload length and flow lookup over an unordered address pair
// flow table held in a single-port synchronous memory.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake         | contents
//  ----------+-----+-------------------+-------------------------------------
//  s_*       | in  | s_tvalid/s_tready | one frame summary per transfer
//  m_*       | out | m_tvalid/m_tready | one classification result per frame
//  cfg_*     | in  | cfg_we            | RTMP port register, write only
//
//  A result is ready when the scan has read the flows in use on a miss, entries
//  0 to h on a hit at entry h, at most MAX_FLOWS; the next frame is taken in the
//  cycle after the result is loaded: the flow memory has one read port and the
//  scan reads one entry per cycle, ending early on the first (lowest) matching entry.
//  Reset clears the flow count and the control state at once; entries at or
//  above the flow count are never read, so the memory needs no clearing pass.
//  A result waits in the output register while m_tready is low; the next frame
//  is taken meanwhile, and its final write waits until that result is gone.
//
`default_nettype none

module tcp_flow_classifier #(
	parameter int unsigned MAX_FLOWS = tfc_pkg::MAX_FLOWS_DEFAULT
) (
	input  wire                       clk,
	input  wire                       arst_n,
	// source_address, dest_address, ip_header_words, tcp_header_words,
	// frame_length, source_port, dest_port
	input  wire                       s_tvalid,
	output logic                      s_tready,
	input  wire  [tfc_pkg::IN_W-1:0]  s_tdata,
	// header_ok, payload_bytes, flow_index, new_flow, table_full, flow_bytes,
	// flow_is_rtmp, zero padding
	output logic                      m_tvalid,
	input  wire                       m_tready,
	output logic [tfc_pkg::OUT_W-1:0] m_tdata,
	input  wire                       cfg_we,
	input  wire  [15:0]               cfg_wdata
);
	import tfc_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_FLOWS);
	localparam int unsigned CNT_W = $clog2(MAX_FLOWS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FLOWS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// unpack the input transfer
	logic [31:0] in_src, in_dst;
	logic [3:0]  in_ipw, in_tcpw;
	logic [15:0] in_flen, in_sport, in_dport;
	assign in_src   = s_tdata[31:0];
	assign in_dst   = s_tdata[63:32];
	assign in_ipw   = s_tdata[67:64];
	assign in_tcpw  = s_tdata[71:68];
	assign in_flen  = s_tdata[87:72];
	assign in_sport = s_tdata[103:88];
	assign in_dport = s_tdata[119:104];

	logic [1:0]       state_q;
	logic [15:0]      rtmp_port_q;
	logic [CNT_W-1:0] count_q;	// flows in use; entries below it are valid
	logic [CNT_W-1:0] scan_q;	// next entry to read
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	flow_entry_t      rd_data_s1;
	logic             found_q;
	logic [IDX_W-1:0] hit_idx_q;
	flow_entry_t      hit_q;

	// frame held for the whole lookup
	logic [31:0] src_q, dst_q;
	logic [15:0] payload_q;
	logic        ok_q, port_hit_q;

	logic        in_fire, out_free, done_fire, rd_en, hit_now, scan_end;
	logic [7:0]  overhead;
	logic        hdr_ok;
	logic [15:0] payload;

	// Ethernet + IP + TCP header bytes, at most 134
	assign overhead = ETH_HDR_BYTES + {2'b00, in_ipw, 2'b00} + {2'b00, in_tcpw, 2'b00};
	assign hdr_ok   = (in_ipw >= MIN_HDR_WORDS) && (in_tcpw >= MIN_HDR_WORDS);
	assign payload  = (hdr_ok && (in_flen > {8'd0, overhead})) ?
		(in_flen - {8'd0, overhead}) : 16'd0;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign done_fire = (state_q == ST_DONE) && out_free;

	// issue reads in order; a match, seen in the cycle after its read, ends the scan
	assign rd_en    = (state_q == ST_SCAN) && (scan_q != count_q);
	assign hit_now  = rd_vld_s1 && pair_match(rd_data_s1, src_q, dst_q);
	assign scan_end = !rd_en && !rd_vld_s1;

	// ---- flow memory ----
	flow_entry_t      mem [MAX_FLOWS];
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	flow_entry_t      wr_data;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[scan_q[IDX_W-1:0]];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// ---- update and result ----
	logic [32:0]      sum;
	logic [31:0]      new_total;
	logic             can_alloc;
	logic [IDX_W-1:0] res_idx;
	logic [IDX_W+IDX_OUT_W-1:0] res_idx_ext;
	logic             res_new, res_full, res_mark;
	logic [31:0]      res_total;

	assign sum       = {1'b0, hit_q.byte_total} + {17'd0, payload_q};
	assign new_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	assign can_alloc = (count_q < CNT_MAX);

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = hit_idx_q;
		wr_data  = hit_q;
		res_idx  = '0;
		res_new  = 1'b0;
		res_full = 1'b0;
		res_mark = 1'b0;
		res_total = 32'd0;
		if (found_q) begin
			// add and saturate into the matched entry
			wr_data.byte_total = new_total;
			wr_data.rtmp_mark  = hit_q.rtmp_mark | port_hit_q;
			wr_en     = done_fire;
			res_idx   = hit_idx_q;
			res_total = new_total;
			res_mark  = wr_data.rtmp_mark;
		end else if (can_alloc) begin
			// open the next free entry, source first
			wr_addr = count_q[IDX_W-1:0];
			wr_data.first_addr  = src_q;
			wr_data.second_addr = dst_q;
			wr_data.byte_total  = {16'd0, payload_q};
			wr_data.rtmp_mark   = port_hit_q;
			wr_en     = done_fire;
			res_idx   = count_q[IDX_W-1:0];
			res_new   = 1'b1;
			res_total = {16'd0, payload_q};
			res_mark  = port_hit_q;
		end else begin
			res_full = 1'b1;
		end
	end

	assign res_idx_ext = {{IDX_OUT_W{1'b0}}, res_idx};

	// ---- control ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rtmp_port_q <= RTMP_PORT_RESET;
			count_q     <= '0;
			scan_q      <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			m_tvalid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				rtmp_port_q <= cfg_wdata;
			end
			// load a new result, else drop the one just taken
			if (done_fire) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			rd_vld_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						scan_q  <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						scan_q <= scan_q + 1'b1;
					end
					if (hit_now) begin
						found_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						if (!found_q && can_alloc) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---- data registers, no reset ----
	always_ff @(posedge clk) begin
		if (in_fire) begin
			src_q      <= in_src;
			dst_q      <= in_dst;
			payload_q  <= payload;
			ok_q       <= hdr_ok;
			port_hit_q <= (in_sport == rtmp_port_q) || (in_dport == rtmp_port_q);
		end
		rd_idx_s1 <= scan_q[IDX_W-1:0];
		if ((state_q == ST_SCAN) && hit_now) begin
			hit_idx_q <= rd_idx_s1;
			hit_q     <= rd_data_s1;
		end
		if (done_fire) begin
			m_tdata <= {6'd0, res_mark, res_total, res_full, res_new,
				res_idx_ext[IDX_OUT_W-1:0], payload_q, ok_q};
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("flow count beyond table size");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_SCAN) && !found_q)
		else $error("accepted frame did not start a scan");

	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ({1'b0, rd_idx_s1} < {1'b0, count_q}))
		else $error("read of an unallocated entry");

	a_alloc_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(done_fire && !found_q && can_alloc) |=> count_q == $past(count_q) + 1'b1)
		else $error("new flow did not advance the flow count");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[24]) |-> (count_q == CNT_MAX))
		else $error("table full reported with free entries");
`endif

endmodule

`default_nettype wire

// ===== tb/tcp_flow_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// tcp_flow_classifier_tb: self-checking bench for the TCP flow classifier
// Drives frame summaries through the stream input and predicts every result
// from a private flow table. Covers header length limits, payload clamping,
// unordered pair matching, RTMP port marking and table exhaustion. Runs these
// under several idle and stall patterns and a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_flow_classifier_tb;

	import tfc_pkg::*;

	localparam int unsigned FLOWS        = MAX_FLOWS_DEFAULT;
	localparam int unsigned QUIET_LIMIT  = 4000;	// cycles with no transfer at all
	localparam int unsigned DRAIN_CYCLES = FLOWS + 8;	// one full scan and some margin
	localparam int unsigned HOLD_CYCLES  = 400;

	// Laid out exactly as s_tdata, first field in the top bits
	typedef struct packed {
		logic [15:0] dst_port;
		logic [15:0] src_port;
		logic [15:0] frame_len;
		logic [3:0]  tcp_words;
		logic [3:0]  ip_words;
		logic [31:0] dst_addr;
		logic [31:0] src_addr;
	} frame_t;

	// Laid out exactly as the low 58 bits of m_tdata
	typedef struct packed {
		logic        flow_is_rtmp;
		logic [31:0] flow_bytes;
		logic        table_full;
		logic        new_flow;
		logic [5:0]  flow_index;
		logic [15:0] payload_bytes;
		logic        header_ok;
	} flow_result_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
	} addr_pair_t;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            s_tvalid  = 1'b0;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata   = '0;
	logic            m_tvalid;
	logic            m_tready  = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic            cfg_we    = 1'b0;
	logic [15:0]     cfg_wdata = '0;

	// Private copy of the flow table and the port register
	logic        flow_used  [FLOWS];
	logic [31:0] flow_addr_a[FLOWS];
	logic [31:0] flow_addr_b[FLOWS];
	logic [31:0] flow_total [FLOWS];
	logic        flow_mark  [FLOWS];
	int unsigned flow_count;
	logic [15:0] rtmp_port_model;

	flow_result_t expected_results[$];
	addr_pair_t   known_pairs[$];
	int unsigned  error_count = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_stall_pct = 0;
	logic         holding = 1'b0;
	event         hold_off;

	tcp_flow_classifier i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// ------------------------------------------------------------------------
	// Prediction: payload length, pair lookup, allocation and marking
	// ------------------------------------------------------------------------
	function automatic flow_result_t classify_frame(input frame_t f);
		flow_result_t r;
		int unsigned  overhead;
		int unsigned  idx;
		int unsigned  i;
		logic         port_hit;
		logic         found;
		logic [32:0]  sum;
		r = '0;
		overhead = ETH_HDR_BYTES + 4 * f.ip_words + 4 * f.tcp_words;
		r.header_ok = (f.ip_words >= MIN_HDR_WORDS) && (f.tcp_words >= MIN_HDR_WORDS);
		// clamp at zero: a frame no longer than its headers carries nothing
		if (r.header_ok && (f.frame_len > overhead)) begin
			r.payload_bytes = 16'(f.frame_len - overhead);
		end
		port_hit = (f.src_port == rtmp_port_model) || (f.dst_port == rtmp_port_model);
		found = 1'b0;
		idx = 0;
		// lowest valid entry holding the pair in either order wins
		for (i = 0; i < FLOWS && !found; i++) begin
			if (flow_used[i] &&
					(((flow_addr_a[i] == f.src_addr) && (flow_addr_b[i] == f.dst_addr)) ||
					((flow_addr_a[i] == f.dst_addr) && (flow_addr_b[i] == f.src_addr)))) begin
				found = 1'b1;
				idx = i;
			end
		end
		if (!found && (flow_count < FLOWS)) begin
			idx = flow_count;
			flow_count++;
			flow_used[idx]   = 1'b1;
			flow_addr_a[idx] = f.src_addr;
			flow_addr_b[idx] = f.dst_addr;
			flow_total[idx]  = '0;
			flow_mark[idx]   = 1'b0;
			r.new_flow = 1'b1;
			found = 1'b1;
		end
		if (!found) begin
			// table full: nothing changes and the flow fields stay zero
			r.table_full = 1'b1;
		end else begin
			sum = flow_total[idx] + r.payload_bytes;
			flow_total[idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			if (port_hit) begin
				flow_mark[idx] = 1'b1;
			end
			r.flow_index   = idx[5:0];
			r.flow_bytes   = flow_total[idx];
			r.flow_is_rtmp = flow_mark[idx];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic frame_t make_frame(input logic [31:0] src, input logic [31:0] dst,
			input logic [3:0] ipw, input logic [3:0] tcpw, input logic [15:0] flen,
			input logic [15:0] sport, input logic [15:0] dport);
		frame_t f;
		f.src_addr  = src;
		f.dst_addr  = dst;
		f.ip_words  = ipw;
		f.tcp_words = tcpw;
		f.frame_len = flen;
		f.src_port  = sport;
		f.dst_port  = dport;
		return f;
	endfunction

	// Reuse pairs already seen (either direction), save for fresh_pct percent of
	// frames, so lookups hit deep into the table; fresh pairs fill it and later find no room.
	function automatic frame_t random_frame(input int unsigned fresh_pct);
		frame_t      f;
		int unsigned pick;
		int unsigned overhead;
		if ((known_pairs.size() == 0) || ($urandom_range(99) < fresh_pct)) begin
			f.src_addr = $urandom;
			f.dst_addr = ($urandom_range(19) == 0) ? f.src_addr : $urandom;
			known_pairs.insert(known_pairs.size(), {f.src_addr, f.dst_addr});
		end else begin
			pick = $urandom_range(known_pairs.size() - 1);
			if ($urandom_range(1) == 0) begin
				f.src_addr = known_pairs[pick].a;
				f.dst_addr = known_pairs[pick].b;
			end else begin
				f.src_addr = known_pairs[pick].b;
				f.dst_addr = known_pairs[pick].a;
			end
		end
		f.ip_words  = 4'(($urandom_range(6) == 0) ? $urandom_range(4) : $urandom_range(15, 5));
		f.tcp_words = 4'(($urandom_range(6) == 0) ? $urandom_range(4) : $urandom_range(15, 5));
		overhead = ETH_HDR_BYTES + 4 * f.ip_words + 4 * f.tcp_words;
		case ($urandom_range(2))
			0: begin
				f.frame_len = 16'($urandom_range(65535));
			end
			1: begin
				f.frame_len = 16'($urandom_range(1500));
			end
			default: begin
				// straddle the point where the payload reaches zero
				f.frame_len = 16'(overhead + $urandom_range(4) - 2);
			end
		endcase
		f.src_port = ($urandom_range(6) == 0) ? rtmp_port_model : 16'($urandom_range(65535));
		f.dst_port = ($urandom_range(6) == 0) ? rtmp_port_model : 16'($urandom_range(65535));
		return f;
	endfunction

	// Offer one frame, idling first as the phase asks; hold tvalid high after
	// the transfer so back-to-back frames need no second assignment.
	task automatic send_frame(input frame_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= f;
		do begin
			@(posedge clk);
		end while (!s_tready);
		expected_results.insert(expected_results.size(), classify_frame(f));
	endtask

	task automatic wait_for_results(input int unsigned settle);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (settle) @(posedge clk);
	endtask

	// Write the port register only once the block has gone quiet
	task automatic write_rtmp_port(input logic [15:0] port);
		wait_for_results(2);
		cfg_we    <= 1'b1;
		cfg_wdata <= port;
		@(posedge clk);
		rtmp_port_model = port;
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Result checking and receiver stalls
	// ------------------------------------------------------------------------
	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	task automatic check_result(input flow_result_t got);
		flow_result_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
			error_count++;
		end else begin
			want = expected_results.pop_front();
			compare_field("header_ok", 32'(want.header_ok), 32'(got.header_ok));
			compare_field("payload_bytes", 32'(want.payload_bytes), 32'(got.payload_bytes));
			compare_field("flow_index", 32'(want.flow_index), 32'(got.flow_index));
			compare_field("new_flow", 32'(want.new_flow), 32'(got.new_flow));
			compare_field("table_full", 32'(want.table_full), 32'(got.table_full));
			compare_field("flow_bytes", want.flow_bytes, got.flow_bytes);
			compare_field("flow_is_rtmp", 32'(want.flow_is_rtmp), 32'(got.flow_is_rtmp));
		end
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			check_result(m_tdata[$bits(flow_result_t)-1:0]);
		end
		m_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
	end

	// Long output hold-off, counted here so the sender keeps offering frames
	initial begin
		forever begin
			@(hold_off);
			@(posedge clk);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding <= 1'b0;
		end
	end

	// Give up when no transfer happens on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Header limits, payload clamping, pair order and both port positions
	task automatic test_header_and_pairs();
		logic [31:0] host_a;
		logic [31:0] host_b;
		host_a = 32'h0A00_0001;
		host_b = 32'hC0A8_0102;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_frame(make_frame(host_a, host_b, 5, 5, 54, RTMP_PORT_RESET, 80));
		send_frame(make_frame(host_b, host_a, 5, 5, 55, 80, 1024));
		send_frame(make_frame(host_a, host_b, 4, 5, 16'hFFFF, 1, 2));
		send_frame(make_frame(host_b, host_a, 5, 4, 16'hFFFF, 3, 4));
		send_frame(make_frame('0, '0, 15, 15, 16'hFFFF, 16'h0000, 16'hFFFF));
		send_frame(make_frame('1, '1, 0, 0, 0, 16'hFFFF, 16'h0000));
		send_frame(make_frame('0, '1, 15, 15, 133, 0, RTMP_PORT_RESET));
		send_frame(make_frame('1, '0, 15, 15, 134, 1, 1));
		send_frame(make_frame('1, '0, 15, 15, 135, 2, 2));
		send_frame(make_frame('0, '0, 5, 5, 16'hFFFF, 5, 6));
		send_frame(make_frame(host_a, host_a, 5, 15, 200, 7, 8));
		wait_for_results(2);
	endtask

	// Port register at both ends of its range, matched on either side
	task automatic test_rtmp_port_extremes();
		write_rtmp_port(16'h0000);
		send_frame(make_frame(32'h1111_0001, 32'h2222_0002, 5, 5, 100, 16'h0000, 7));
		send_frame(make_frame(32'h2222_0002, 32'h1111_0001, 5, 5, 100, 7, 7));
		send_frame(make_frame(32'h3333_0003, 32'h4444_0004, 5, 5, 100, 9, 16'h0000));
		write_rtmp_port(16'hFFFF);
		send_frame(make_frame(32'h5555_0005, 32'h6666_0006, 6, 8, 300, 16'hFFFF, 1));
		send_frame(make_frame(32'h7777_0007, 32'h5555_0005, 6, 8, 300, 1, 16'hFFFF));
		wait_for_results(2);
	endtask

	task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
			input int unsigned stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_frame(random_frame(10));
		wait_for_results(2);
	endtask

	// Fill every entry, then miss with new pairs and hit the old ones
	task automatic test_table_full();
		send_idle_pct  = 0;
		recv_stall_pct = 30;
		while (flow_count < FLOWS) begin
			send_frame(random_frame(100));
		end
		repeat (12) send_frame(random_frame(100));
		repeat (30) send_frame(random_frame(0));
		wait_for_results(2);
	endtask

	// Hold the output off long enough for the block to stall its input
	task automatic test_output_hold_off();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		-> hold_off;
		repeat (40) send_frame(random_frame(10));
		wait_for_results(2);
	endtask

	initial begin
		for (int i = 0; i < FLOWS; i++) begin
			flow_used[i] = 1'b0;
		end
		flow_count = 0;
		rtmp_port_model = RTMP_PORT_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_and_pairs();
		test_rtmp_port_extremes();
		write_rtmp_port(16'($urandom_range(65535)));
		test_random_traffic(400, 0, 0);
		test_table_full();
		write_rtmp_port(16'($urandom_range(65535)));
		test_random_traffic(400, 85, 0);
		write_rtmp_port(16'($urandom_range(65535)));
		test_random_traffic(400, 0, 85);
		test_output_hold_off();
		write_rtmp_port(RTMP_PORT_RESET);
		test_random_traffic(400, 17, 17);

		wait_for_results(DRAIN_CYCLES);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
src/tfc_pkg.sv
src/tcp_flow_classifier.sv
tb/tcp_flow_classifier_tb.sv
